[sv/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_NOW(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tat_pkg.sv]
package tat_pkg;

  localparam int MAX_USERS = 256;
  localparam int TAG_BYTES = 4;

  localparam int TAG_W     = 32;
  localparam int AW        = $clog2(MAX_USERS);
  localparam int CNT_W     = $clog2(MAX_USERS + 1);
  localparam int IDX_W     = 8;
  localparam int CNT_OUT_W = 9;
  localparam int ENTRY_W   = TAG_W + 1;

  localparam logic [TAG_W-1:0] TAG_MASK =
    (TAG_BYTES >= 4) ? {TAG_W{1'b1}} : TAG_W'((64'd1 << (8 * TAG_BYTES)) - 64'd1);

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_SET    = 2'd1,
    FN_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    RS_DONE     = 2'd0,
    RS_AUTH_CHG = 2'd1,
    RS_ADDED    = 2'd2,
    RS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] user_count;
    logic                 auth_bit;
    logic [IDX_W-1:0]     index;
    logic                 found;
    status_e              status;
  } res_t;

endpackage

[sv/tag_access_table_top.sv]
// tag access table: stored tags with one authorization bit each
// input beats carry a command in tuser (lookup, set authorization, clear) with
// a tag and the requested bit in tdata; every input beat yields exactly one
// output beat with the status in tuser and found flag, index, stored bit and
// the resulting tag count in tdata
// tags and bits share one 33-bit wide ram; a lookup or set walks it from
// index 0 upward, one read per cycle, and stops at the first match
// every result is registered in res_q and then moved to the output register
// that drives m_axis_tvalid; clear and unused codes skip the search
// one command is in flight at a time: no input beat is taken before the last
// result moves to the output register, and the next one can be taken in the
// cycle after that move
// s_axis_tready is high whenever no command is in flight, also while an
// output beat still waits, so one finished result sits in the output
// register while the next command searches; a stalled receiver holds that
// beat and the search after it waits to hand over its result
// reset empties the table (count to zero); ram contents are not cleared,
// only entries below the count are ever read, so no clearing pass is needed
module tag_access_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tag [31:0], auth [32], zero fill [39:33]
  input  logic [tat_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func [1:0]
  input  logic [tat_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // found [0], index [8:1], auth_bit [9], user_count [18:10], zero fill [23:19]
  output logic [tat_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [tat_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import tat_pkg::*;

  state_e             state_q, state_d;
  func_e              func_q, func_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic               auth_q, auth_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      cmp_idx_q, cmp_idx_d;
  res_t               res_q, res_d;
  res_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  logic [TAG_W-1:0]   rd_tag;
  logic               rd_auth;
  logic               hit;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               in_acc;
  logic               out_load;

  assign rd_tag  = rd_data[TAG_W-1:0];
  assign rd_auth = rd_data[TAG_W];
  assign hit     = pend_q && (((rd_tag ^ tag_q) & TAG_MASK) == '0);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  tat_ram #(
    .Width(ENTRY_W),
    .Depth(MAX_USERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(issue_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    tag_d     = tag_q;
    auth_d    = auth_q;
    count_d   = count_q;
    issue_d   = issue_q;
    pend_d    = 1'b0;
    cmp_idx_d = cmp_idx_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = count_q[AW-1:0];
    wr_data   = {auth_q, tag_q};
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d  = func_e'(s_axis_tuser);
          tag_d   = s_axis_tdata[TAG_W-1:0];
          auth_d  = s_axis_tdata[TAG_W];
          issue_d = '0;
          res_d   = '0;
          unique case (func_e'(s_axis_tuser))
            FN_LOOKUP, FN_SET: begin
              state_d = ST_SEARCH;
            end
            FN_CLEAR: begin
              count_d = '0;
              state_d = ST_RESULT;
            end
            default: begin
              res_d.user_count = CNT_OUT_W'(count_q);
              state_d          = ST_RESULT;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        rd_en = (issue_q < count_q) && !hit;
        if (rd_en) begin
          issue_d   = issue_q + CNT_W'(1);
          cmp_idx_d = issue_q[AW-1:0];
        end
        pend_d = rd_en;
        res_d  = '0;
        if (hit) begin
          res_d.found    = 1'b1;
          res_d.index    = IDX_W'(cmp_idx_q);
          res_d.auth_bit = rd_auth;
          if ((func_q == FN_SET) && (rd_auth != auth_q)) begin
            wr_en          = 1'b1;
            wr_addr        = cmp_idx_q;
            wr_data        = {auth_q, rd_tag};
            res_d.status   = RS_AUTH_CHG;
            res_d.auth_bit = auth_q;
          end
          res_d.user_count = CNT_OUT_W'(count_q);
          state_d          = ST_RESULT;
        end else if (issue_q == count_q) begin
          // every stored tag compared without a match
          res_d.user_count = CNT_OUT_W'(count_q);
          if (func_q == FN_SET) begin
            if (count_q >= CNT_W'(MAX_USERS)) begin
              res_d.status = RS_FULL;
            end else begin
              wr_en            = 1'b1;
              count_d          = count_q + CNT_W'(1);
              res_d.status     = RS_ADDED;
              res_d.index      = IDX_W'(count_q);
              res_d.auth_bit   = auth_q;
              res_d.user_count = CNT_OUT_W'(count_q + CNT_W'(1));
            end
          end
          state_d = ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    tag_q     <= tag_d;
    auth_q    <= auth_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.user_count, out_q.auth_bit, out_q.index,
                          out_q.found};
  assign m_axis_tuser  = out_q.status;

endmodule

[sv/tat_ram.sv]
module tat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/tat_checker.sv]
`include "assert_macros.svh"

module tat_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tat_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [tat_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import tat_pkg::*;

  logic [1:0]           o_status;
  logic                 o_found;
  logic [IDX_W-1:0]     o_index;
  logic [CNT_OUT_W-1:0] o_count;

  assign o_status = m_axis_tuser;
  assign o_found  = m_axis_tdata[0];
  assign o_index  = m_axis_tdata[8:1];
  assign o_count  = m_axis_tdata[18:10];

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
              "output beat dropped or changed")

  `ASSERT_IMP(a_count_bound, clk_i, rst_ni, m_axis_tvalid,
              o_count <= CNT_OUT_W'(MAX_USERS), "tag count beyond table size")

  `ASSERT_IMP(a_full_clean, clk_i, rst_ni, m_axis_tvalid && (o_status == RS_FULL),
              !o_found && (o_index == '0) && (o_count == CNT_OUT_W'(MAX_USERS)),
              "table full beat with bad fields")

  `ASSERT_IMP(a_added_new, clk_i, rst_ni, m_axis_tvalid && (o_status == RS_ADDED),
              !o_found && (CNT_OUT_W'(o_index) + CNT_OUT_W'(1) == o_count),
              "added tag not at the end of the table")

endmodule

bind tag_access_table_top tat_checker u_tat_checker (.*);
